/* rtl/hlrp_pkg.sv */
// Package: types and codes for the hi/lo relocation pair tracker.
package hlrp_pkg;

    localparam int unsigned NUM_REGS_C = 32;

    typedef enum logic [2:0] {
        ACT_CLEAR_ALL   = 3'd0,
        ACT_CLEAR_STATE = 3'd1,
        ACT_HI16        = 3'd2,
        ACT_LO16        = 3'd3,
        ACT_SAVE        = 3'd4,
        ACT_REACH       = 3'd5
    } t_action;

    localparam logic [1:0] ST_UNSET    = 2'd0;
    localparam logic [1:0] ST_SET      = 2'd1;
    localparam logic [1:0] ST_USED     = 2'd2;
    localparam logic [1:0] ST_CONFLICT = 2'd3;

    localparam logic [2:0] RES_OK       = 3'd0;
    localparam logic [2:0] RES_NOT_SET  = 3'd1;
    localparam logic [2:0] RES_CONFLICT = 3'd2;
    localparam logic [2:0] RES_MISMATCH = 3'd3;
    localparam logic [2:0] RES_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]  st;
        logic [15:0] hi;
        logic [9:0]  rel;
    } t_entry;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] address;
        logic [31:0] instruction;
        logic [9:0]  reloc_id;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic        target_valid;
        logic [31:0] target_address;
        logic [9:0]  lo_reloc_id;
        logic        hi_target_written;
        logic [9:0]  hi_reloc_id;
        logic        merged;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_LO_RD, S_LO_WAIT, S_LO_DO, S_LO_HI, S_SEARCH, S_DECIDE,
        S_MRG_RD, S_MRG_WAIT, S_MRG_WR, S_OUT
    } t_state;

    // Per-register merge rule.
    function automatic t_entry merge_entry(t_entry d, t_entry s, logic d_clean);
        t_entry r;
        logic dl, sl;
        r  = d;
        dl = (d.st == ST_SET) || (d.st == ST_USED);
        sl = (s.st == ST_SET) || (s.st == ST_USED);
        if (d_clean) begin
            r = s;
        end else if (d.st == ST_UNSET && s.st == ST_UNSET) begin
            r = d;
        end else if (dl && sl && d.hi == s.hi && d.rel == s.rel) begin
            r.st = (d.st == ST_USED || s.st == ST_USED) ? ST_USED : ST_SET;
        end else begin
            r.st = ST_CONFLICT;
        end
        return r;
    endfunction

endpackage

/* rtl/hlrp_target_ram.sv */
// Reloc target address memory, one write and one registered read port.
module hlrp_target_ram #(
    parameter int unsigned RELOC_SLOTS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(RELOC_SLOTS)-1:0] i_waddr,
    input  logic [31:0]                    i_wdata,
    input  logic [$clog2(RELOC_SLOTS)-1:0] i_raddr,
    output logic [31:0]                    o_rdata
);
    logic [31:0] r_mem [RELOC_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/hlrp_future_ram.sv */
// Saved register states, one row of NUM_REGS entries per slot.
module hlrp_future_ram #(
    parameter int unsigned DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  hlrp_pkg::t_entry         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output hlrp_pkg::t_entry         o_rdata
);
    import hlrp_pkg::*;
    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/hi_lo_relocation_pair_tracker.sv */
// Top level: hi/lo relocation pair tracker with register, saved-state and target memories.
//
//  channel | dir | signals                         | transfer when
//  input   | in  | i_in_valid, o_in_stall, i_in    | i_in_valid & !o_in_stall
//  output  | out | o_out_valid, i_out_stall, o_out | o_out_valid & !i_out_stall
//
// One item at a time. Hi16, unused actions: straight to output. Lo16: register read, target
// read, check and write, on success then a state for the second target write. Clear all/state:
// a pipelined read-modify-write pass over the registers. Save/reach: address search over
// FUTURE_SLOTS entries; a merge or copy adds a read, wait, write pass over the registers.
// After reset a clearing pass zeroes the register memory; input stalls until it ends.
// Input stalls while the result waits.
module hi_lo_relocation_pair_tracker #(
    parameter int unsigned FUTURE_SLOTS = 16,
    parameter int unsigned RELOC_SLOTS  = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  hlrp_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output hlrp_pkg::t_out o_out
);
    import hlrp_pkg::*;

    localparam int unsigned FW = (FUTURE_SLOTS > 1) ? $clog2(FUTURE_SLOTS) : 1;
    localparam int unsigned RW = $clog2(RELOC_SLOTS);
    localparam int unsigned DEPTH = (2 ** FW) * NUM_REGS_C;
    localparam int unsigned DW = $clog2(DEPTH);
    localparam int unsigned SW = $clog2(FUTURE_SLOTS + 1);

    // Current register table: small array, one registered read port.
    t_entry r_regs [NUM_REGS_C];
    t_entry r_reg_rd;
    logic   reg_we;
    logic [4:0] reg_waddr, reg_raddr;
    t_entry reg_wdata;

    always_ff @(posedge i_clk) begin
        if (reg_we) begin
            r_regs[reg_waddr] <= reg_wdata;
        end
        r_reg_rd <= r_regs[reg_raddr];
    end

    // Saved-state addresses and valid bits are flip-flops, read at a counter index.
    logic [31:0] r_faddr [FUTURE_SLOTS];
    logic [FUTURE_SLOTS-1:0] r_fvalid;

    t_state r_state, n_state;
    t_in    r_in;
    t_out   r_out, n_out;
    logic   r_out_valid;
    logic   r_clean, n_clean;
    logic [5:0]  r_cnt, n_cnt;
    logic [SW-1:0] r_scan, n_scan;
    logic [FW-1:0] r_hit, n_hit, r_free, n_free;
    logic   r_found, n_found, r_has_free, n_has_free;
    logic   r_boot, n_boot;
    logic   r_mode_copy, n_mode_copy;

    logic   fut_we;
    logic [DW-1:0] fut_waddr, fut_raddr;
    t_entry fut_wdata, fut_rd;
    logic   tgt_we;
    logic [RW-1:0] tgt_waddr, tgt_raddr;
    logic [31:0] tgt_wdata, tgt_rd;

    hlrp_future_ram #(.DEPTH(DEPTH)) u_future (
        .i_clk(i_clk), .i_we(fut_we), .i_waddr(fut_waddr), .i_wdata(fut_wdata),
        .i_raddr(fut_raddr), .o_rdata(fut_rd)
    );

    hlrp_target_ram #(.RELOC_SLOTS(RELOC_SLOTS)) u_target (
        .i_clk(i_clk), .i_we(tgt_we), .i_waddr(tgt_waddr), .i_wdata(tgt_wdata),
        .i_raddr(tgt_raddr), .o_rdata(tgt_rd)
    );

    logic [4:0]  reg_idx;
    logic [15:0] imm;
    logic [31:0] sx, formed;
    logic [FW-1:0] slot;
    logic [FW-1:0] scan_idx;
    assign reg_idx  = r_in.instruction[20:16];
    assign imm      = r_in.instruction[15:0];
    assign sx       = {{16{imm[15]}}, imm};
    assign formed   = {r_reg_rd.hi, 16'h0000} + sx;
    assign slot     = r_found ? r_hit : r_free;
    assign scan_idx = r_scan[FW-1:0];

    // Input is accepted only when idle and the output register is free.
    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid || r_boot;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    logic fv_set, fv_clr, fv_clr_all;
    logic fa_we;

    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_clean     = r_clean;
        n_cnt       = r_cnt;
        n_scan      = r_scan;
        n_hit       = r_hit;
        n_free      = r_free;
        n_found     = r_found;
        n_has_free  = r_has_free;
        n_boot      = r_boot;
        n_mode_copy = r_mode_copy;
        reg_we      = 1'b0;
        reg_waddr   = reg_idx;
        reg_wdata   = r_reg_rd;
        reg_raddr   = reg_idx;
        fut_we      = 1'b0;
        fut_waddr   = {slot, r_cnt[4:0]};
        fut_wdata   = r_reg_rd;
        fut_raddr   = {slot, r_cnt[4:0]};
        tgt_we      = 1'b0;
        tgt_waddr   = RW'(r_in.reloc_id);
        tgt_wdata   = formed;
        tgt_raddr   = RW'(r_reg_rd.rel);
        fv_set      = 1'b0;
        fv_clr      = 1'b0;
        fv_clr_all  = 1'b0;
        fa_we       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (r_boot) begin
                    n_state = S_CLR;
                    n_cnt   = '0;
                end else if (i_in_valid && !o_in_stall) begin
                    n_out   = '0;
                    n_cnt   = '0;
                    n_scan  = '0;
                    n_found = 1'b0;
                    n_has_free = 1'b0;
                    unique case (i_in.action) inside
                        ACT_CLEAR_ALL, ACT_CLEAR_STATE: n_state = S_CLR;
                        ACT_HI16: n_state = S_OUT;
                        ACT_LO16: n_state = S_LO_RD;
                        ACT_SAVE, ACT_REACH: n_state = S_SEARCH;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_CLR: begin
                // read entry r_cnt, write back entry r_cnt - 1 with status unset;
                // at boot the whole entry is zeroed
                reg_raddr    = r_cnt[4:0];
                reg_waddr    = r_cnt[4:0] - 5'd1;
                reg_we       = (r_cnt != 6'd0);
                reg_wdata    = r_reg_rd;
                reg_wdata.st = ST_UNSET;
                if (r_boot) reg_wdata = '0;
                n_cnt        = r_cnt + 6'd1;
                if (r_cnt[5]) begin
                    n_clean = 1'b1;
                    if (r_boot) begin
                        n_boot  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        if (r_in.action == ACT_CLEAR_ALL) fv_clr_all = 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            S_LO_RD: begin
                n_state = S_LO_WAIT;   // register read in flight
            end
            S_LO_WAIT: begin
                n_state = S_LO_DO;     // target read in flight
            end
            S_LO_DO: begin
                if (r_reg_rd.st == ST_UNSET) begin
                    n_out.status = RES_NOT_SET;
                end else if (r_reg_rd.st == ST_CONFLICT) begin
                    n_out.status = RES_CONFLICT;
                end else if (r_reg_rd.st == ST_USED && tgt_rd != formed) begin
                    n_out.status = RES_MISMATCH;
                    n_out.target_address = formed;
                end else begin
                    n_out.target_valid   = 1'b1;
                    n_out.target_address = formed;
                    n_out.lo_reloc_id    = r_in.reloc_id;
                    if (r_reg_rd.st == ST_SET) begin
                        n_out.hi_target_written = 1'b1;
                        n_out.hi_reloc_id       = r_reg_rd.rel;
                    end
                    reg_we       = 1'b1;
                    reg_wdata.st = ST_USED;
                    tgt_we       = 1'b1;
                    n_state      = S_LO_HI;
                end
                if (n_state == S_LO_DO) n_state = S_OUT;
            end
            S_LO_HI: begin
                // second write: hi reloc's target, same formed address
                if (r_out.hi_target_written) begin
                    tgt_we    = 1'b1;
                    tgt_waddr = RW'(r_out.hi_reloc_id);
                    tgt_wdata = r_out.target_address;
                end
                if (r_out.hi_target_written &&
                    RW'(r_out.hi_reloc_id) == RW'(r_in.reloc_id)) begin
                    tgt_we = 1'b0;   // lo write already holds the same value
                end
                n_state = S_OUT;
            end
            S_SEARCH: begin
                if (r_scan == SW'(FUTURE_SLOTS)) begin
                    n_state = S_DECIDE;
                end else begin
                    if (!r_found && r_fvalid[scan_idx] &&
                        r_faddr[scan_idx] == r_in.address) begin
                        n_found = 1'b1;
                        n_hit   = scan_idx;
                    end
                    if (!r_has_free && !r_fvalid[scan_idx]) begin
                        n_has_free = 1'b1;
                        n_free     = scan_idx;
                    end
                    n_scan = r_scan + SW'(1);
                end
            end
            S_DECIDE: begin
                n_cnt = '0;
                if (r_found) begin
                    n_out.merged = 1'b1;
                    n_mode_copy  = 1'b0;
                    n_state      = S_MRG_RD;
                    if (r_in.action == ACT_REACH) fv_clr = 1'b1;
                end else if (r_in.action == ACT_REACH) begin
                    n_state = S_OUT;
                end else if (r_has_free) begin
                    fv_set      = 1'b1;
                    fa_we       = 1'b1;
                    n_mode_copy = 1'b1;
                    n_state     = S_MRG_RD;
                end else begin
                    n_out.status = RES_FULL;
                    n_state      = S_OUT;
                end
            end
            S_MRG_RD: begin
                reg_raddr = r_cnt[4:0];
                n_state   = S_MRG_WAIT;
            end
            S_MRG_WAIT: begin
                reg_raddr = r_cnt[4:0];   // hold the entry for the write cycle
                n_state   = S_MRG_WR;
            end
            S_MRG_WR: begin
                if (r_in.action == ACT_REACH) begin
                    reg_we    = 1'b1;
                    reg_waddr = r_cnt[4:0];
                    reg_wdata = merge_entry(r_reg_rd, fut_rd, r_clean);
                end else begin
                    fut_we    = 1'b1;
                    fut_wdata = r_mode_copy ? r_reg_rd : merge_entry(fut_rd, r_reg_rd, 1'b0);
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt[4:0] == 5'd31) begin
                    if (r_in.action == ACT_REACH) n_clean = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_MRG_RD;
                end
            end
            S_OUT: begin
                // hi16 writes the register entry straight from the held input
                if (r_in.action == ACT_HI16) begin
                    reg_we    = 1'b1;
                    reg_waddr = reg_idx;
                    reg_wdata = '{st: ST_SET, hi: imm, rel: r_in.reloc_id};
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_clean     <= 1'b1;
            r_fvalid    <= '0;
            r_boot      <= 1'b1;
            r_cnt       <= '0;
            r_scan      <= '0;
            r_found     <= 1'b0;
            r_has_free  <= 1'b0;
            r_hit       <= '0;
            r_free      <= '0;
            r_mode_copy <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clean     <= n_clean;
            r_cnt       <= n_cnt;
            r_scan      <= n_scan;
            r_found     <= n_found;
            r_has_free  <= n_has_free;
            r_hit       <= n_hit;
            r_free      <= n_free;
            r_boot      <= n_boot;
            r_mode_copy <= n_mode_copy;
            if (fv_clr_all) begin
                r_fvalid <= '0;
            end else if (fv_set) begin
                r_fvalid[r_free] <= 1'b1;
            end else if (fv_clr) begin
                r_fvalid[r_hit] <= 1'b0;
            end
            if (r_state == S_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == S_IDLE && i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
        if (fa_we) begin
            r_faddr[r_free] <= r_in.address;
        end
    end

endmodule
